### src/fss_pkg.sv
// Shared types, sizes and the query and name case-folding functions of the fuzzy subsequence scorer.
package fss_pkg;

   localparam int QUERY_MAX = 64;
   localparam int NAME_MAX  = 256;

   localparam int QADDR_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
   localparam int QLEN_W  = $clog2(QUERY_MAX + 1);
   localparam int POS_W   = $clog2(NAME_MAX + 1);
   localparam int CHAR_W  = 16;
   localparam int CONS_W  = 7;
   localparam int RS_W    = 20;
   localparam int SCORE_W = 15;

   localparam logic [CONS_W-1:0] CONS_MAX = '1;
   localparam int LEN_SHIFT = 5;

   localparam logic [RS_W-1:0] RUN_BASE   = RS_W'(15);
   localparam logic [RS_W-1:0] RUN_STEP   = RS_W'(5);
   localparam logic [RS_W-1:0] WORD_BONUS = RS_W'(8);
   localparam logic signed [RS_W-1:0] SCORE_HI = RS_W'(16383);
   localparam logic signed [RS_W-1:0] SCORE_LO = -RS_W'(16384);

   localparam logic [CHAR_W-1:0] CH_SPACE      = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 16'h005F;
   localparam logic [CHAR_W-1:0] CH_HYPHEN     = 16'h002D;
   localparam logic [CHAR_W-1:0] CH_DOT        = 16'h002E;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_NAME   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CHAR_W-1:0] char_code;
      logic              last_of_name;
   } item_type;

   typedef struct packed {
      logic               en;
      logic [QADDR_W-1:0] addr;
      logic [CHAR_W-1:0]  data;
   } qwrite_type;

   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
      logic               matched;
      logic               query_too_long;
   } result_type;

   function automatic logic [CHAR_W-1:0] fold_query(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 16'h0041 && c <= 16'h005A) r = c + 16'd32;
      else if (c >= 16'h00C0 && c <= 16'h00DE && c != 16'h00D7) r = c + 16'd32;
      else if (c >= 16'h0100 && c <= 16'h0137 && !c[0]) r = c + 16'd1;
      else if (c >= 16'h0139 && c <= 16'h0148 && c[0]) r = c + 16'd1;
      else if (c >= 16'h014A && c <= 16'h0177 && !c[0]) r = c + 16'd1;
      else if (c >= 16'h0179 && c <= 16'h017E && c[0]) r = c + 16'd1;
      else if (c >= 16'h0410 && c <= 16'h042F) r = c + 16'd32;
      else if (c >= 16'h0400 && c <= 16'h040F) r = c + 16'd80;
      else if (c >= 16'h0391 && c <= 16'h03A1) r = c + 16'd32;
      else if (c >= 16'h03A3 && c <= 16'h03A9) r = c + 16'd32;
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] fold_name(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 16'h0041 && c <= 16'h005A) r = c + 16'd32;
      return r;
   endfunction

endpackage

### src/fss_query_mem.sv
// Query character memory: one write port, one registered read port with write bypass.
module fss_query_mem (
   input  logic                       clock,
   input  fss_pkg::qwrite_type        wr,
   input  logic [fss_pkg::QADDR_W-1:0] rd_addr,
   output logic [fss_pkg::CHAR_W-1:0]  rd_data
);
   import fss_pkg::*;

   logic [CHAR_W-1:0] mem [QUERY_MAX];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (wr.en && wr.addr == rd_addr) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fss_match_core.sv
// Query bookkeeping and per-character greedy match scoring with its state registers.
module fss_match_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  fss_pkg::item_type           item,
   input  logic [fss_pkg::CHAR_W-1:0]  qchar,
   output fss_pkg::qwrite_type         wr,
   output logic [fss_pkg::QADDR_W-1:0] rd_addr,
   output fss_pkg::result_type         result
);
   import fss_pkg::*;

   logic [QLEN_W-1:0] qlen_ff, qlen_in;
   logic              ovf_ff, ovf_in;
   logic [QLEN_W-1:0] idx_ff, idx_in;
   logic              lmv_ff, lmv_in;
   logic [POS_W-1:0]  lmp_ff, lmp_in;
   logic [CONS_W-1:0] cons_ff, cons_in;
   logic [RS_W-1:0]   rs_ff, rs_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CHAR_W-1:0] prev_ff, prev_in;

   logic [CHAR_W-1:0]      fch;
   logic                   hit;
   logic [POS_W-1:0]       base;
   logic [POS_W-1:0]       gap;
   logic                   bonus;
   logic [RS_W-1:0]        fin;
   logic signed [RS_W-1:0] fin_s;

   always_comb begin
      qlen_in = qlen_ff;
      ovf_in  = ovf_ff;
      idx_in  = idx_ff;
      lmv_in  = lmv_ff;
      lmp_in  = lmp_ff;
      cons_in = cons_ff;
      rs_in   = rs_ff;
      pos_in  = pos_ff;
      prev_in = prev_ff;
      wr      = '0;
      result  = '0;
      fch     = fold_name(item.char_code);
      hit     = (idx_ff < qlen_ff) && (fch == qchar);
      base    = lmv_ff ? lmp_ff + POS_W'(1) : '0;
      gap     = pos_ff - base;
      bonus   = (pos_ff == '0) || (prev_ff == CH_SPACE) || (prev_ff == CH_UNDERSCORE) ||
                (prev_ff == CH_HYPHEN) || (prev_ff == CH_DOT);
      fin     = '0;
      fin_s   = '0;
      if (fire) begin
         case (item.kind)
            KIND_CLEAR: begin
               qlen_in = '0;
               ovf_in  = 1'b0;
            end
            KIND_APPEND: begin
               if (qlen_ff < QLEN_W'(QUERY_MAX)) begin
                  wr.en   = 1'b1;
                  wr.addr = qlen_ff[QADDR_W-1:0];
                  wr.data = fold_query(item.char_code);
                  qlen_in = qlen_ff + QLEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            KIND_NAME: begin
               if (pos_ff < POS_W'(NAME_MAX)) begin
                  if (hit) begin
                     if (gap == '0) begin
                        if (cons_ff != CONS_MAX) cons_in = cons_ff + CONS_W'(1);
                        rs_in = rs_ff + RUN_BASE + RUN_STEP * RS_W'(cons_in);
                     end else begin
                        cons_in = '0;
                        rs_in   = rs_ff - RS_W'(gap);
                     end
                     if (bonus) rs_in = rs_in + WORD_BONUS;
                     lmv_in = 1'b1;
                     lmp_in = pos_ff;
                     idx_in = idx_ff + QLEN_W'(1);
                  end
                  prev_in = item.char_code;
                  pos_in  = pos_ff + POS_W'(1);
               end
               if (item.last_of_name) begin
                  result.valid          = 1'b1;
                  result.query_too_long = ovf_ff;
                  if (qlen_ff == '0) begin
                     result.matched = 1'b1;
                  end else if (idx_in >= qlen_ff) begin
                     result.matched = 1'b1;
                     fin   = rs_in - RS_W'(pos_in >> LEN_SHIFT);
                     fin_s = $signed(fin);
                     if (fin_s > SCORE_HI) fin_s = SCORE_HI;
                     if (fin_s < SCORE_LO) fin_s = SCORE_LO;
                     result.score = fin_s[SCORE_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
         if (item.kind == KIND_CLEAR || item.kind == KIND_APPEND ||
             (item.kind == KIND_NAME && item.last_of_name)) begin
            idx_in  = '0;
            lmv_in  = 1'b0;
            lmp_in  = '0;
            cons_in = '0;
            rs_in   = '0;
            pos_in  = '0;
            prev_in = '0;
         end
      end
   end

   assign rd_addr = idx_in[QADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff <= '0;
         ovf_ff  <= 1'b0;
         idx_ff  <= '0;
         lmv_ff  <= 1'b0;
         cons_ff <= '0;
         rs_ff   <= '0;
         pos_ff  <= '0;
         prev_ff <= '0;
      end else begin
         qlen_ff <= qlen_in;
         ovf_ff  <= ovf_in;
         idx_ff  <= idx_in;
         lmv_ff  <= lmv_in;
         cons_ff <= cons_in;
         rs_ff   <= rs_in;
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      lmp_ff <= lmp_in;
   end

endmodule

### src/fuzzy_subsequence_scorer_core.sv
// Top level of the fuzzy subsequence scorer: input beat register, match core, result register.
// Path: an accepted beat is registered in the input register; when it advances, its result
// is computed combinationally and registered in the result register.
// Throughput: one beat per cycle unless a result not yet taken stalls the pipeline.
// Reset (synchronous, active high) empties the query, the name state and both registers;
// query memory contents are not cleared.
module fuzzy_subsequence_scorer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] char_code
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic        req_tlast,   // last_of_name
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [14:0] score, [15] matched, [16] query_too_long
);
   import fss_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   item_type            s1_item_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_data_ff;
   logic                advance;
   qwrite_type          wr;
   logic [QADDR_W-1:0]  rd_addr;
   logic [CHAR_W-1:0]   qchar;
   result_type          result;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   fss_match_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (s1_item_ff),
      .qchar   (qchar),
      .wr      (wr),
      .rd_addr (rd_addr),
      .result  (result)
   );

   fss_query_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (qchar)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff.kind         <= req_tuser;
         s1_item_ff.char_code    <= req_tdata;
         s1_item_ff.last_of_name <= req_tlast;
      end
      if (advance && result.valid) begin
         rsp_data_ff <= {7'd0, result.query_too_long, result.matched, result.score};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### tb/fss_checker.sv
// Scoreboard for the fuzzy subsequence scorer: tracks the query and name state, checks result beats.
module fss_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          mismatches,
   output int          pending
);
   import fss_pkg::*;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      matched;
      logic                      too_long;
   } score_beat_type;

   score_beat_type    expected_scores[$];
   logic [CHAR_W-1:0] query_chars[QUERY_MAX];
   int                query_len;
   bit                query_ovf;
   int                next_idx;
   bit                have_match;
   int                match_pos;
   int                streak;
   int                running;
   int                name_pos;
   logic [CHAR_W-1:0] prev_ch;

   function automatic logic [CHAR_W-1:0] lower_query_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] f;
      f = c;
      if ((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0410 && c <= 16'h042F) ||
          (c >= 16'h0391 && c <= 16'h03A9 && c != 16'h03A2) ||
          (c >= 16'h00C0 && c <= 16'h00DE && c != 16'h00D7))
         f = c + 16'd32;
      else if (c >= 16'h0400 && c <= 16'h040F)
         f = c + 16'd80;
      else if (((c >= 16'h0100 && c <= 16'h0137) || (c >= 16'h014A && c <= 16'h0177)) && !c[0])
         f = c + 16'd1;
      else if (((c >= 16'h0139 && c <= 16'h0148) || (c >= 16'h0179 && c <= 16'h017E)) && c[0])
         f = c + 16'd1;
      return f;
   endfunction

   task automatic restart_name();
      next_idx   = 0;
      have_match = 1'b0;
      match_pos  = 0;
      streak     = 0;
      running    = 0;
      name_pos   = 0;
      prev_ch    = '0;
   endtask

   task automatic score_beat(input logic [1:0] k, input logic [CHAR_W-1:0] c, input logic l);
      logic [CHAR_W-1:0] folded;
      int                gap;
      int                total;
      score_beat_type    want;
      case (k)
         KIND_CLEAR: begin
            query_len = 0;
            query_ovf = 1'b0;
            restart_name();
         end
         KIND_APPEND: begin
            if (query_len < QUERY_MAX) begin
               query_chars[query_len] = lower_query_char(c);
               query_len++;
            end else begin
               query_ovf = 1'b1;
            end
            restart_name();
         end
         KIND_NAME: begin
            if (name_pos < NAME_MAX) begin
               folded = (c >= 16'h0041 && c <= 16'h005A) ? c + 16'd32 : c;
               if (next_idx < query_len && folded == query_chars[next_idx]) begin
                  gap = name_pos - (have_match ? match_pos + 1 : 0);
                  if (gap == 0) begin
                     if (streak < 127) streak++;
                     running += 15 + 5 * streak;
                  end else begin
                     streak = 0;
                     running -= gap;
                  end
                  if (name_pos == 0 || prev_ch == CH_SPACE || prev_ch == CH_UNDERSCORE ||
                      prev_ch == CH_HYPHEN || prev_ch == CH_DOT)
                     running += 8;
                  have_match = 1'b1;
                  match_pos  = name_pos;
                  next_idx++;
               end
               prev_ch = c;
               name_pos++;
            end
            if (l) begin
               total        = 0;
               want.matched = (query_len == 0 || next_idx >= query_len);
               if (query_len != 0 && want.matched) total = running - name_pos / 32;
               if (total > 16383) total = 16383;
               if (total < -16384) total = -16384;
               want.score    = total[SCORE_W-1:0];
               want.too_long = query_ovf;
               expected_scores.insert(expected_scores.size(), want);
               restart_name();
            end
         end
         default: ;
      endcase
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_result();
      score_beat_type got;
      score_beat_type want;
      got.score    = rsp_tdata[14:0];
      got.matched  = rsp_tdata[15];
      got.too_long = rsp_tdata[16];
      if (expected_scores.size() == 0) begin
         note_mismatch($sformatf("unexpected result beat score %0d matched %b too_long %b",
                                 got.score, got.matched, got.too_long));
      end else begin
         want = expected_scores.pop_front();
         if (got !== want)
            note_mismatch($sformatf(
               "result mismatch: score %0d/%0d matched %b/%b too_long %b/%b (exp/got)",
               want.score, got.score, want.matched, got.matched, want.too_long, got.too_long));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_scores.delete();
         mismatches = 0;
         query_len  = 0;
         query_ovf  = 1'b0;
         restart_name();
      end else begin
         if (req_tvalid && req_tready) score_beat(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      pending = expected_scores.size();
   end

endmodule

### tb/tb.sv
// Top of the fuzzy subsequence scorer testbench: clock, reset, stimulus, back-pressure and verdict.
module tb;
   import fss_pkg::*;

   localparam int         ITEM_TARGET = 1750;
   localparam logic [1:0] KIND_SPARE  = 2'd3;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [23:0] rsp_tdata;
   int          mismatches;
   int          pending;

   int idle_pct   = 0;
   int stall_pct  = 0;
   int beats_sent = 0;
   int names_sent = 0;
   int phase_idle[4]  = '{0, 52, 0, 23};
   int phase_stall[4] = '{0, 0, 52, 23};
   logic [CHAR_W-1:0] query_folded[$];

   fuzzy_subsequence_scorer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   fss_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #2000000;
      $display("tb failed");
      $finish;
   end

   task automatic send_beat(input logic [1:0] k, input logic [CHAR_W-1:0] c, input logic l);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= c;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (k != KIND_SPARE) beats_sent++;
   endtask

   function automatic logic [CHAR_W-1:0] rand_filler();
      logic [CHAR_W-1:0] c;
      case ($urandom_range(5))
         0: c = 16'h0061 + 16'($urandom_range(25));
         1: c = 16'h0041 + 16'($urandom_range(25));
         2: begin
            case ($urandom_range(3))
               0: c = CH_SPACE;
               1: c = CH_UNDERSCORE;
               2: c = CH_HYPHEN;
               default: c = CH_DOT;
            endcase
         end
         3: c = 16'h0030 + 16'($urandom_range(9));
         4: c = 16'($urandom);
         default: c = 16'h00C0 + 16'($urandom_range(63));
      endcase
      return c;
   endfunction

   task automatic load_query();
      int                len;
      int                r;
      logic [CHAR_W-1:0] up;
      logic [CHAR_W-1:0] low;
      r   = $urandom_range(11);
      len = (r == 0) ? 0 : (r == 1) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      query_folded.delete();
      send_beat(KIND_CLEAR, 16'($urandom), $urandom_range(7) == 0);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(7))
            0: begin
               low = 16'h0061 + 16'($urandom_range(25));
               up  = low - 16'd32;
            end
            1: begin
               low = 16'h00E0 + 16'($urandom_range(30));
               if (low == 16'h00F7) low = 16'h00F8;
               up = low - 16'd32;
            end
            2: begin
               up  = 16'h0100 + 16'(2 * $urandom_range(27));
               low = up + 16'd1;
            end
            3: begin
               up  = 16'h014A + 16'(2 * $urandom_range(22));
               low = up + 16'd1;
            end
            4: begin
               if ($urandom_range(1)) begin
                  up  = 16'h0410 + 16'($urandom_range(31));
                  low = up + 16'd32;
               end else begin
                  up  = 16'h0400 + 16'($urandom_range(15));
                  low = up + 16'd80;
               end
            end
            5: begin
               up = 16'h0391 + 16'($urandom_range(17));
               if (up == 16'h03A2) up = 16'h03A9;
               low = up + 16'd32;
            end
            6: begin
               if ($urandom_range(1)) up = 16'h0139 + 16'(2 * $urandom_range(7));
               else up = 16'h0179 + 16'(2 * $urandom_range(2));
               low = up + 16'd1;
            end
            default: begin
               case ($urandom_range(3))
                  0: low = 16'h0030 + 16'($urandom_range(9));
                  1: low = rand_filler();
                  2: low = ($urandom_range(1)) ? 16'h00D7 : 16'hFFFF;
                  default: low = 16'($urandom);
               endcase
               up = low;
            end
         endcase
         send_beat(KIND_APPEND, $urandom_range(1) ? up : low, $urandom_range(7) == 0);
         if (query_folded.size() < QUERY_MAX) query_folded.insert(query_folded.size(), low);
      end
   endtask

   task automatic send_name(input bit cut);
      logic [CHAR_W-1:0] chars[$];
      logic [CHAR_W-1:0] c;
      int                skip;
      int                n;
      bit                long_name;
      bit                at_front;
      long_name = ($urandom_range(149) == 0) || (names_sent == 3);
      names_sent++;
      if (query_folded.size() == 0 || $urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 12)) chars.insert(chars.size(), rand_filler());
      end else begin
         skip = ($urandom_range(9) == 0) ? $urandom_range(query_folded.size() - 1) : -1;
         foreach (query_folded[i]) begin
            if ($urandom_range(2) == 0) begin
               repeat ($urandom_range(1, 3)) chars.insert(chars.size(), rand_filler());
            end
            c = query_folded[i];
            if (c >= 16'h0061 && c <= 16'h007A && $urandom_range(1)) c = c - 16'd32;
            if (i != skip) chars.insert(chars.size(), c);
         end
         repeat ($urandom_range(2)) chars.insert(chars.size(), rand_filler());
      end
      if (long_name) begin
         at_front = $urandom_range(1);
         repeat ($urandom_range(250, 300)) begin
            if (at_front) chars.push_front(rand_filler());
            else chars.insert(chars.size(), rand_filler());
         end
      end
      n = cut ? (chars.size() + 1) / 2 : chars.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(24) == 0) send_beat(KIND_SPARE, 16'($urandom), 1'($urandom));
         send_beat(KIND_NAME, chars[i], !cut && i == n - 1);
      end
   endtask

   initial begin
      int n;
      bit cut_last;
      int phase;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty query, then ignored spare kind
      send_beat(KIND_NAME, 16'h0051, 1'b1);
      send_beat(KIND_SPARE, 16'hFFFF, 1'b1);
      send_beat(KIND_APPEND, 16'h0041, 1'b1);
      send_beat(KIND_APPEND, 16'h00C0, 1'b0);
      send_beat(KIND_APPEND, 16'h0410, 1'b0);
      send_beat(KIND_APPEND, 16'h0391, 1'b0);
      send_beat(KIND_APPEND, 16'h017D, 1'b0);
      // separator bonus, consecutive run, upper-case name fold
      send_beat(KIND_NAME, CH_HYPHEN, 1'b0);
      send_beat(KIND_NAME, 16'h0041, 1'b0);
      send_beat(KIND_NAME, 16'h00E0, 1'b0);
      send_beat(KIND_NAME, 16'h0430, 1'b0);
      send_beat(KIND_NAME, 16'h03B1, 1'b0);
      send_beat(KIND_NAME, 16'h017E, 1'b1);
      send_beat(KIND_NAME, 16'h007A, 1'b1);
      // abandon a name with a query append
      send_beat(KIND_NAME, 16'h0061, 1'b0);
      send_beat(KIND_APPEND, 16'h0400, 1'b0);
      send_beat(KIND_CLEAR, 16'h0000, 1'b1);
      send_beat(KIND_APPEND, 16'hFFFF, 1'b0);
      send_beat(KIND_APPEND, 16'h00D7, 1'b0);
      send_beat(KIND_APPEND, 16'h0000, 1'b0);
      send_beat(KIND_NAME, 16'hFFFF, 1'b0);
      send_beat(KIND_NAME, 16'h00D7, 1'b0);
      send_beat(KIND_NAME, 16'h0000, 1'b1);

      while (beats_sent < ITEM_TARGET) begin
         phase     = (beats_sent * 4 / ITEM_TARGET) % 4;
         idle_pct  = phase_idle[phase];
         stall_pct = phase_stall[phase];
         load_query();
         n        = $urandom_range(1, 6);
         cut_last = ($urandom_range(5) == 0);
         for (int k = 0; k < n; k++) send_name(cut_last && k == n - 1);
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
